/* src/memory_decoder_address_translate_assert.svh */
`ifndef MEMORY_DECODER_ADDRESS_TRANSLATE_ASSERT_SVH
`define MEMORY_DECODER_ADDRESS_TRANSLATE_ASSERT_SVH

// same-cycle implication
`define MDAT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define MDAT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* src/mdat_pkg.sv */
`default_nettype none
package mdat_pkg;

    localparam int HOST_ADDR_BITS_DEF = 52;
    localparam int DEV_ADDR_BITS      = 52;
    localparam int MEDIA_BITS         = 53;
    localparam int GRAN_BASE_BITS     = 8;

    localparam logic [MEDIA_BITS-1:0] MEDIA_RESET = MEDIA_BITS'(268435456);

    localparam logic [1:0] OP_REG_WR  = 2'd0;
    localparam logic [1:0] OP_HOST_RD = 2'd1;
    localparam logic [1:0] OP_HOST_WR = 2'd2;

    localparam logic [2:0] REG_BASE_LO = 3'd0;
    localparam logic [2:0] REG_BASE_HI = 3'd1;
    localparam logic [2:0] REG_SIZE_LO = 3'd2;
    localparam logic [2:0] REG_SIZE_HI = 3'd3;
    localparam logic [2:0] REG_CTRL    = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_RD_ERR  = 2'd1;
    localparam logic [1:0] ST_WR_DROP = 2'd2;

    localparam int CTRL_COMMIT_BIT    = 9;
    localparam int CTRL_COMMITTED_BIT = 10;

    typedef struct packed {
        logic        en;
        logic [2:0]  idx;
        logic [31:0] data;
    } t_reg_wr;

    typedef struct packed {
        logic [63:0]           base;
        logic [63:0]           size;
        logic [3:0]            gran;
        logic [3:0]            ways;
        logic [MEDIA_BITS-1:0] media;
    } t_dec_state;

endpackage
`default_nettype wire

/* src/mdat_regs.sv */
`default_nettype none
module mdat_regs (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  mdat_pkg::t_reg_wr                   i_wr,
    input  wire                                 i_cfg_valid,
    input  wire  [mdat_pkg::MEDIA_BITS-1:0]     i_cfg_media_size,
    output mdat_pkg::t_dec_state                o_state,
    output logic                                o_committed_next
);
    import mdat_pkg::*;

    logic [63:0]           r_base;
    logic [63:0]           r_size;
    logic [3:0]            r_gran;
    logic [3:0]            r_ways;
    logic                  r_committed;
    logic [MEDIA_BITS-1:0] r_media;
    logic                  ctrl_wr;

    assign ctrl_wr = i_wr.en && (i_wr.idx == REG_CTRL);

    always_comb begin
        o_committed_next = r_committed;
        if (ctrl_wr) begin
            o_committed_next = i_wr.data[CTRL_COMMIT_BIT] | i_wr.data[CTRL_COMMITTED_BIT];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= '0;
            r_size      <= '0;
            r_gran      <= '0;
            r_ways      <= '0;
            r_committed <= 1'b0;
            r_media     <= MEDIA_RESET;
        end else begin
            if (i_cfg_valid) begin
                r_media <= i_cfg_media_size;
            end
            if (i_wr.en) begin
                case (i_wr.idx)
                    REG_BASE_LO: r_base[31:0]  <= i_wr.data;
                    REG_BASE_HI: r_base[63:32] <= i_wr.data;
                    REG_SIZE_LO: r_size[31:0]  <= i_wr.data;
                    REG_SIZE_HI: r_size[63:32] <= i_wr.data;
                    REG_CTRL: begin
                        r_gran <= i_wr.data[3:0];
                        r_ways <= i_wr.data[7:4];
                    end
                    default: ;
                endcase
            end
            r_committed <= o_committed_next;
        end
    end

    assign o_state.base  = r_base;
    assign o_state.size  = r_size;
    assign o_state.gran  = r_gran;
    assign o_state.ways  = r_ways;
    assign o_state.media = r_media;

endmodule
`default_nettype wire

/* src/mdat_xlate.sv */
`default_nettype none
module mdat_xlate #(
    parameter int HOST_ADDR_BITS = mdat_pkg::HOST_ADDR_BITS_DEF
) (
    input  mdat_pkg::t_dec_state                 i_state,
    input  wire  [1:0]                           i_op,
    input  wire  [HOST_ADDR_BITS-1:0]            i_addr,
    output logic [1:0]                           o_status,
    output logic [mdat_pkg::DEV_ADDR_BITS-1:0]   o_dev
);
    import mdat_pkg::*;

    logic [63:0] addr64;
    logic [64:0] diff;
    logic [63:0] off;
    logic        in_range;
    logic [4:0]  low_bits;
    logic [5:0]  sh;
    logic [63:0] keep_mask;
    logic [63:0] dev64;
    logic        hit;

    always_comb begin
        addr64    = 64'(i_addr);
        diff      = {1'b0, addr64} - {1'b0, i_state.base};
        off       = diff[63:0];
        in_range  = !diff[64] && (off < i_state.size);
        low_bits  = 5'(GRAN_BASE_BITS) + {1'b0, i_state.gran};
        sh        = {1'b0, low_bits} + {2'b0, i_state.ways};
        keep_mask = (64'd1 << low_bits) - 64'd1;
        dev64     = (off & keep_mask) | ((off >> sh) << low_bits);
        hit       = in_range && (dev64 < 64'(i_state.media));

        o_status = ST_OK;
        o_dev    = '0;
        if (i_op == OP_HOST_RD || i_op == OP_HOST_WR) begin
            if (hit) begin
                o_dev = dev64[DEV_ADDR_BITS-1:0];
            end else if (i_op == OP_HOST_RD) begin
                o_status = ST_RD_ERR;
            end else begin
                o_status = ST_WR_DROP;
            end
        end
    end

endmodule
`default_nettype wire

/* src/memory_decoder_address_translate.sv */
// Single host-managed memory decoder. Each item is either a decoder register
// write (base and size as 32-bit halves, control word) or a host read/write
// access that is range-checked against base and size, translated by the
// granularity and ways fields, and checked against the media size. An item
// passes through an input register and a result register: its result shows on
// the outputs once the result register takes it, one item accepted per cycle
// while i_ready does not hold the output, with register writes seen by the
// very next item. The media size port is always ready.
`default_nettype none
`include "memory_decoder_address_translate_assert.svh"
module memory_decoder_address_translate #(
    parameter int HOST_ADDR_BITS = mdat_pkg::HOST_ADDR_BITS_DEF
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_valid,
    output logic                                 o_ready,
    input  wire  [1:0]                           i_op,
    input  wire  [2:0]                           i_reg_index,
    input  wire  [31:0]                          i_write_data,
    input  wire  [HOST_ADDR_BITS-1:0]            i_host_address,
    output logic                                 o_valid,
    input  wire                                  i_ready,
    output logic [1:0]                           o_status,
    output logic [mdat_pkg::DEV_ADDR_BITS-1:0]   o_device_address,
    output logic                                 o_committed,
    input  wire                                  i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire  [mdat_pkg::MEDIA_BITS-1:0]      i_cfg_media_size
);
    import mdat_pkg::*;

    logic                      r_in_valid;
    logic [1:0]                r_op;
    logic [2:0]                r_idx;
    logic [31:0]               r_data;
    logic [HOST_ADDR_BITS-1:0] r_addr;

    logic                      r_out_valid;
    logic [1:0]                r_status;
    logic [DEV_ADDR_BITS-1:0]  r_dev;
    logic                      r_committed;

    logic                      adv;
    logic                      load_in;
    t_reg_wr                   reg_wr;
    t_dec_state                dec_state;
    logic                      committed_next;
    logic [1:0]                n_status;
    logic [DEV_ADDR_BITS-1:0]  n_dev;

    assign adv         = !r_out_valid || i_ready;
    assign o_ready     = !r_in_valid || adv;
    assign load_in     = i_valid && o_ready;
    assign o_cfg_ready = 1'b1;

    assign reg_wr.en   = r_in_valid && adv && (r_op == OP_REG_WR);
    assign reg_wr.idx  = r_idx;
    assign reg_wr.data = r_data;

    mdat_regs u_regs (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_wr             (reg_wr),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_media_size (i_cfg_media_size),
        .o_state          (dec_state),
        .o_committed_next (committed_next)
    );

    mdat_xlate #(
        .HOST_ADDR_BITS (HOST_ADDR_BITS)
    ) u_xlate (
        .i_state  (dec_state),
        .i_op     (r_op),
        .i_addr   (r_addr),
        .o_status (n_status),
        .o_dev    (n_dev)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (adv) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_in) begin
            r_op   <= i_op;
            r_idx  <= i_reg_index;
            r_data <= i_write_data;
            r_addr <= i_host_address;
        end
        if (r_in_valid && adv) begin
            r_status    <= n_status;
            r_dev       <= n_dev;
            r_committed <= committed_next;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_status         = r_status;
    assign o_device_address = r_dev;
    assign o_committed      = r_committed;

    `MDAT_ASSERT_NOW(a_err_no_addr, i_clk, i_rst_n, o_valid && (o_status != ST_OK), o_device_address == '0)
    `MDAT_ASSERT_NOW(a_ready_when_empty, i_clk, i_rst_n, !o_valid, o_ready)
    `MDAT_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, r_in_valid && !adv, r_in_valid)
    `MDAT_ASSERT_NEXT(a_commit_seen, i_clk, i_rst_n, reg_wr.en && (reg_wr.idx == REG_CTRL) && reg_wr.data[CTRL_COMMIT_BIT], o_valid && o_committed)

endmodule
`default_nettype wire

/* test/tb.sv */
`default_nettype none
module tb;
    import mdat_pkg::*;

    localparam logic [1:0] OP_UNUSED    = 2'd3;
    localparam logic [2:0] REG_SPARE_LO = 3'd5;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;
    localparam int CTRL_ERROR_BIT = 11;
    localparam logic [51:0] ADDR_MAX = '1;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 150;
    localparam int NUM_PHASES  = 6;
    localparam int NUM_ROWS    = 27;

    typedef struct packed {
        logic [1:0]               status;
        logic [DEV_ADDR_BITS-1:0] dev;
        logic                     committed;
    } decode_result_t;

    typedef struct packed {
        logic [1:0]     op;
        logic [2:0]     idx;
        logic [31:0]    data;
        logic [51:0]    addr;
        logic           typed;
        decode_result_t result;
    } directed_row_t;

    logic                     i_clk            = 1'b0;
    logic                     i_rst_n          = 1'b0;
    logic                     i_valid          = 1'b0;
    logic [1:0]               i_op             = '0;
    logic [2:0]               i_reg_index      = '0;
    logic [31:0]              i_write_data     = '0;
    logic [51:0]              i_host_address   = '0;
    logic                     i_ready          = 1'b0;
    logic                     i_cfg_valid      = 1'b0;
    logic [MEDIA_BITS-1:0]    i_cfg_media_size = '0;
    logic                     o_ready;
    logic                     o_valid;
    logic [1:0]               o_status;
    logic [DEV_ADDR_BITS-1:0] o_device_address;
    logic                     o_committed;
    logic                     o_cfg_ready;

    memory_decoder_address_translate dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_op            (i_op),
        .i_reg_index     (i_reg_index),
        .i_write_data    (i_write_data),
        .i_host_address  (i_host_address),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_status        (o_status),
        .o_device_address(o_device_address),
        .o_committed     (o_committed),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_media_size(i_cfg_media_size)
    );

    logic [63:0]           dec_base;
    logic [63:0]           dec_size;
    logic [31:0]           dec_ctrl;
    logic [MEDIA_BITS-1:0] media_limit;
    decode_result_t        pending_decodes[$];
    logic                  row_typed  = 1'b0;
    decode_result_t        row_result = '0;
    int                    mismatches = 0;
    int                    cycles     = 0;
    int                    burst_left = 0;

    directed_row_t directed_table [NUM_ROWS] = '{
        '{OP_HOST_RD, REG_BASE_LO, 32'h0, 52'h0, 1'b1, '{ST_RD_ERR, 52'h0, 1'b0}},
        '{OP_HOST_WR, REG_BASE_LO, 32'h0, ADDR_MAX, 1'b1, '{ST_WR_DROP, 52'h0, 1'b0}},
        '{OP_UNUSED, REG_SPARE_HI, 32'hFFFF_FFFF, ADDR_MAX, 1'b1, '{ST_OK, 52'h0, 1'b0}},
        '{OP_REG_WR, REG_SPARE_LO, 32'hFFFF_FFFF, 52'h0, 1'b1, '{ST_OK, 52'h0, 1'b0}},
        '{OP_REG_WR, REG_BASE_LO, 32'h0000_1000, 52'h0, 1'b1, '{ST_OK, 52'h0, 1'b0}},
        '{OP_REG_WR, REG_BASE_HI, 32'h0, 52'h0, 1'b1, '{ST_OK, 52'h0, 1'b0}},
        '{OP_REG_WR, REG_SIZE_LO, 32'h0010_0000, 52'h0, 1'b1, '{ST_OK, 52'h0, 1'b0}},
        '{OP_REG_WR, REG_SIZE_HI, 32'h0, 52'h0, 1'b1, '{ST_OK, 52'h0, 1'b0}},
        '{OP_HOST_RD, REG_BASE_LO, 32'h0, 52'h1000, 1'b1, '{ST_OK, 52'h0, 1'b0}},
        '{OP_REG_WR, REG_CTRL, 32'h0000_0200, 52'h0, 1'b1, '{ST_OK, 52'h0, 1'b1}},
        '{OP_HOST_RD, REG_BASE_LO, 32'h0, 52'hFFF, 1'b1, '{ST_RD_ERR, 52'h0, 1'b1}},
        '{OP_HOST_RD, REG_BASE_LO, 32'h0, 52'h10_1000, 1'b1, '{ST_RD_ERR, 52'h0, 1'b1}},
        '{OP_HOST_WR, REG_BASE_LO, 32'h0, 52'h10_0FFF, 1'b0, '0},
        '{OP_REG_WR, REG_CTRL, 32'hFFFF_FFFF, 52'h0, 1'b1, '{ST_OK, 52'h0, 1'b1}},
        '{OP_HOST_RD, REG_BASE_LO, 32'h0, 52'h1_3345, 1'b0, '0},
        '{OP_REG_WR, REG_CTRL, 32'hFFFF_FDFF, 52'h0, 1'b0, '0},
        '{OP_REG_WR, REG_CTRL, 32'h0, 52'h0, 1'b1, '{ST_OK, 52'h0, 1'b0}},
        '{OP_REG_WR, REG_BASE_LO, 32'hFFFF_FFFF, 52'h0, 1'b1, '{ST_OK, 52'h0, 1'b0}},
        '{OP_REG_WR, REG_BASE_HI, 32'hFFFF_FFFF, 52'h0, 1'b1, '{ST_OK, 52'h0, 1'b0}},
        '{OP_REG_WR, REG_SIZE_HI, 32'hFFFF_FFFF, 52'h0, 1'b1, '{ST_OK, 52'h0, 1'b0}},
        '{OP_REG_WR, REG_SIZE_LO, 32'hFFFF_FFFF, 52'h0, 1'b1, '{ST_OK, 52'h0, 1'b0}},
        '{OP_HOST_RD, REG_BASE_LO, 32'h0, ADDR_MAX, 1'b1, '{ST_RD_ERR, 52'h0, 1'b0}},
        '{OP_REG_WR, REG_BASE_LO, 32'h0, 52'h0, 1'b1, '{ST_OK, 52'h0, 1'b0}},
        '{OP_REG_WR, REG_BASE_HI, 32'h0, 52'h0, 1'b1, '{ST_OK, 52'h0, 1'b0}},
        '{OP_HOST_RD, REG_BASE_LO, 32'h0, ADDR_MAX, 1'b1, '{ST_RD_ERR, 52'h0, 1'b0}},
        '{OP_HOST_WR, REG_BASE_LO, 32'h0, 52'hFFF_FFFF, 1'b1,
          '{ST_OK, 52'hFFF_FFFF, 1'b0}},
        '{OP_HOST_RD, REG_BASE_LO, 32'h0, 52'h1000_0000, 1'b1, '{ST_RD_ERR, 52'h0, 1'b0}}
    };

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic decode_result_t decode_item(input logic [1:0] op, input logic [2:0] idx,
                                                   input logic [31:0] data,
                                                   input logic [51:0] addr);
        decode_result_t res;
        logic [63:0]    off;
        logic [63:0]    keep;
        logic [63:0]    high;
        logic [63:0]    dev;
        int unsigned    low_bits;
        int unsigned    ways;
        logic           hit;
        res = '0;
        hit = 1'b0;
        dev = '0;
        if (op == OP_REG_WR) begin
            case (idx)
                REG_BASE_LO: dec_base[31:0] = data;
                REG_BASE_HI: dec_base[63:32] = data;
                REG_SIZE_LO: dec_size[31:0] = data;
                REG_SIZE_HI: dec_size[63:32] = data;
                REG_CTRL: begin
                    dec_ctrl = data;
                    if (data[CTRL_COMMIT_BIT]) begin
                        dec_ctrl[CTRL_COMMIT_BIT]    = 1'b0;
                        dec_ctrl[CTRL_ERROR_BIT]     = 1'b0;
                        dec_ctrl[CTRL_COMMITTED_BIT] = 1'b1;
                    end
                end
                default: ;
            endcase
        end else if (op == OP_HOST_RD || op == OP_HOST_WR) begin
            if ({12'd0, addr} >= dec_base) begin
                off = {12'd0, addr} - dec_base;
                if (off < dec_size) begin
                    low_bits = GRAN_BASE_BITS + dec_ctrl[3:0];
                    ways     = dec_ctrl[7:4];
                    keep     = off & ((64'd1 << low_bits) - 64'd1);
                    high     = (off >> (low_bits + ways)) << low_bits;
                    dev      = keep | high;
                    hit      = dev < {11'd0, media_limit};
                end
            end
            if (hit) begin
                res.dev = dev[DEV_ADDR_BITS-1:0];
            end else begin
                res.status = (op == OP_HOST_RD) ? ST_RD_ERR : ST_WR_DROP;
            end
        end
        res.committed = dec_ctrl[CTRL_COMMITTED_BIT];
        return res;
    endfunction

    always @(posedge i_clk) begin
        decode_result_t predicted;
        decode_result_t due;
        if (!i_rst_n) begin
            dec_base    = '0;
            dec_size    = '0;
            dec_ctrl    = '0;
            media_limit = MEDIA_RESET;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                media_limit = i_cfg_media_size;
            end
            if (i_valid && o_ready) begin
                predicted = decode_item(i_op, i_reg_index, i_write_data, i_host_address);
                pending_decodes.push_back(row_typed ? row_result : predicted);
            end
            if (o_valid && i_ready) begin
                if (pending_decodes.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected result: status %0d dev %h committed %0d",
                                 o_status, o_device_address, o_committed);
                    end
                end else begin
                    due = pending_decodes.pop_front();
                    if (o_status !== due.status || o_device_address !== due.dev ||
                        o_committed !== due.committed) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch: expected status %0d dev %h committed %0d, %s",
                                     due.status, due.dev, due.committed, "got below");
                            $display("          actual   status %0d dev %h committed %0d",
                                     o_status, o_device_address, o_committed);
                        end
                    end
                end
            end
        end
    end

    initial begin
        int mode;
        int hold;
        hold = 0;
        forever begin
            mode = $urandom_range(0, 2);
            repeat ($urandom_range(20, 80)) begin
                @(negedge i_clk);
                case (mode)
                    0: i_ready <= 1'b1;
                    1: i_ready <= 1'($urandom_range(0, 1));
                    default: begin
                        if (hold > 0) begin
                            hold--;
                            i_ready <= 1'b0;
                        end else if ($urandom_range(0, 7) == 0) begin
                            hold = $urandom_range(1, 8);
                            i_ready <= 1'b0;
                        end else begin
                            i_ready <= 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    task automatic send_item(input logic [1:0] op, input logic [2:0] idx,
                             input logic [31:0] data, input logic [51:0] addr,
                             input logic typed, input decode_result_t result);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        i_valid        <= 1'b1;
        i_op           <= op;
        i_reg_index    <= idx;
        i_write_data   <= data;
        i_host_address <= addr;
        row_typed      <= typed;
        row_result     <= result;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain_decodes();
        i_valid <= 1'b0;
        burst_left = 0;
        while (pending_decodes.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_media_size(input logic [MEDIA_BITS-1:0] value);
        i_cfg_media_size <= value;
        i_cfg_valid      <= 1'b1;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic program_window();
        logic [63:0] r;
        logic [63:0] base;
        logic [63:0] size;
        logic [31:0] ctrl;
        int          span;
        r    = {$urandom, $urandom};
        base = {12'd0, r[51:0]};
        if ($urandom_range(0, 1) == 0) base[11:0] = '0;
        span = $urandom_range(1, 44);
        r    = {$urandom, $urandom};
        size = (r & ((64'd1 << span) - 64'd1)) + 64'd1;
        if ($urandom_range(0, 9) == 0) size = '1;
        ctrl = $urandom;
        ctrl[CTRL_COMMIT_BIT] = ($urandom_range(0, 3) != 0);
        send_item(OP_REG_WR, REG_BASE_LO, base[31:0], 52'($urandom), 1'b0, '0);
        send_item(OP_REG_WR, REG_BASE_HI, base[63:32], 52'($urandom), 1'b0, '0);
        send_item(OP_REG_WR, REG_SIZE_LO, size[31:0], 52'($urandom), 1'b0, '0);
        send_item(OP_REG_WR, REG_SIZE_HI, size[63:32], 52'($urandom), 1'b0, '0);
        send_item(OP_REG_WR, REG_CTRL, ctrl, 52'($urandom), 1'b0, '0);
    endtask

    initial begin
        logic [63:0]           r;
        logic [63:0]           a;
        logic [1:0]            op;
        logic [2:0]            idx;
        logic [31:0]           data;
        logic [51:0]           addr;
        logic [MEDIA_BITS-1:0] media;
        int                    kind;
        int                    phase_items;
        bit                    paused;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        foreach (directed_table[k]) begin
            send_item(directed_table[k].op, directed_table[k].idx, directed_table[k].data,
                      directed_table[k].addr, directed_table[k].typed,
                      directed_table[k].result);
        end
        drain_decodes();
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            r = {$urandom, $urandom};
            case (phase)
                0: media = (53'd1 << 52) - 53'd1;
                1: media = '0;
                2: media = 53'd1 << 52;
                5: media = MEDIA_BITS'($urandom_range(1, 1 << 24));
                default: media = {1'b0, r[51:0]};
            endcase
            write_media_size(media);
            program_window();
            phase_items = 5;
            paused = 1'b0;
            while (phase_items < PHASE_ITEMS) begin
                kind = $urandom_range(0, 99);
                op   = ($urandom_range(0, 1) == 0) ? OP_HOST_RD : OP_HOST_WR;
                idx  = 3'($urandom_range(0, 7));
                data = $urandom;
                r    = {$urandom, $urandom};
                addr = r[51:0];
                if (kind < 60) begin
                    if (dec_size != 0) begin
                        a    = dec_base + ({$urandom, $urandom} % dec_size);
                        addr = a[51:0];
                    end
                end else if (kind < 70) begin
                    case ($urandom_range(0, 3))
                        0: a = dec_base - 64'd1;
                        1: a = dec_base;
                        2: a = dec_base + dec_size - 64'd1;
                        default: a = dec_base + dec_size;
                    endcase
                    addr = a[51:0];
                end else if (kind < 78) begin
                    op  = OP_REG_WR;
                    idx = 3'($urandom_range(0, 4));
                end else if (kind < 82) begin
                    program_window();
                    phase_items += 5;
                    continue;
                end else begin
                    op = 2'($urandom_range(0, 3));
                end
                send_item(op, idx, data, addr, 1'b0, '0);
                if (!(op == OP_UNUSED || (op == OP_REG_WR && idx > REG_CTRL))) begin
                    phase_items++;
                end
                if (!paused && phase_items >= PHASE_ITEMS / 2) begin
                    drain_decodes();
                    paused = 1'b1;
                end
            end
            drain_decodes();
        end
        repeat (10) @(negedge i_clk);
        if (mismatches == 0 && pending_decodes.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire

/* files.f */
+incdir+src
src/mdat_pkg.sv
src/mdat_regs.sv
src/mdat_xlate.sv
src/memory_decoder_address_translate.sv
test/tb.sv
